### src/rkbi_pkg.sv
package rkbi_pkg;

    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int POS_WIDTH       = 32;
    localparam int HOLD_WIDTH      = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MOVE_THRESHOLD        = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_PRESS_TICKS      = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LONG_LONG_PRESS_TICKS = 2'd2;

    localparam logic [CFG_DATA_WIDTH-1:0] RST_MOVE_THRESHOLD        = 16'd1;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_LONG_PRESS_TICKS      = 16'd50;
    localparam logic [CFG_DATA_WIDTH-1:0] RST_LONG_LONG_PRESS_TICKS = 16'd100;

    localparam logic MODE_EDGE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    typedef struct packed {
        logic mode;
        logic a_level;
        logic button_level;
    } in_item_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] position;
        logic                        moved;
        logic                        direction;
        logic                        pressed;
        logic                        released;
        logic                        click;
        logic                        long_click;
        logic                        long_down;
        logic                        long_long_down;
    } out_item_t;

    typedef struct packed {
        logic signed [POS_WIDTH-1:0] position;
        logic                        moved;
        logic                        direction;
    } knob_res_t;

    typedef struct packed {
        logic pressed;
        logic released;
        logic click;
        logic long_click;
        logic long_down;
        logic long_long_down;
    } btn_ev_t;

endpackage

### src/rkbi_knob.sv
module rkbi_knob #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  step_en,
    input  rkbi_pkg::in_item_t                    item,
    input  logic [rkbi_pkg::CFG_DATA_WIDTH-1:0]   move_threshold,
    output rkbi_pkg::knob_res_t                   res
);
    import rkbi_pkg::*;

    logic [COUNT_WIDTH-1:0] edge_count_reg, edge_count_next;
    logic [COUNT_WIDTH-1:0] edge_seen_reg, edge_seen_next;
    logic [POS_WIDTH-1:0]   position_reg, position_next;
    logic [POS_WIDTH-1:0]   reported_reg, reported_next;

    logic [COUNT_WIDTH-1:0] delta;
    logic [POS_WIDTH-1:0]   delta_ext;
    logic [POS_WIDTH-1:0]   pos_sum;
    logic [POS_WIDTH-1:0]   pos_gap;
    logic [POS_WIDTH-1:0]   mag;
    logic                   fire;

    assign delta = edge_count_reg - edge_seen_reg;

    generate
        if (COUNT_WIDTH >= POS_WIDTH) begin : g_trunc
            assign delta_ext = delta[POS_WIDTH-1:0];
        end else begin : g_sext
            assign delta_ext = {{(POS_WIDTH-COUNT_WIDTH){delta[COUNT_WIDTH-1]}}, delta};
        end
    endgenerate

    assign pos_sum = position_reg + delta_ext;
    assign pos_gap = pos_sum - reported_reg;
    assign mag     = pos_gap[POS_WIDTH-1] ? (~pos_gap + 1'b1) : pos_gap;
    assign fire    = mag > {{(POS_WIDTH-CFG_DATA_WIDTH){1'b0}}, move_threshold};

    always_comb begin
        edge_count_next = edge_count_reg;
        edge_seen_next  = edge_seen_reg;
        position_next   = position_reg;
        reported_next   = reported_reg;
        res.position    = position_reg;
        res.moved       = 1'b0;
        res.direction   = 1'b0;
        if (item.mode == MODE_TICK) begin
            res.position  = pos_sum;
            res.moved     = fire;
            res.direction = delta[COUNT_WIDTH-1];
        end
        if (step_en) begin
            if (item.mode == MODE_EDGE) begin
                edge_count_next = item.a_level ? edge_count_reg + 1'b1
                                               : edge_count_reg - 1'b1;
            end else begin
                edge_seen_next = edge_count_reg;
                position_next  = pos_sum;
                if (fire) begin
                    reported_next = pos_sum;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_count_reg <= '0;
            edge_seen_reg  <= '0;
            position_reg   <= '0;
            reported_reg   <= '0;
        end else begin
            edge_count_reg <= edge_count_next;
            edge_seen_reg  <= edge_seen_next;
            position_reg   <= position_next;
            reported_reg   <= reported_next;
        end
    end

endmodule

### src/rkbi_button.sv
module rkbi_button (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  rkbi_pkg::in_item_t                  item,
    input  logic [rkbi_pkg::CFG_DATA_WIDTH-1:0] long_press_ticks,
    input  logic [rkbi_pkg::CFG_DATA_WIDTH-1:0] long_long_press_ticks,
    output rkbi_pkg::btn_ev_t                   ev
);
    import rkbi_pkg::*;

    logic                  prev_pressed_reg, prev_pressed_next;
    logic                  is_up_reg, is_up_next;
    logic                  is_down_reg, is_down_next;
    logic                  long_reg, long_next;
    logic                  long_long_reg, long_long_next;
    logic [HOLD_WIDTH-1:0] hold_reg, hold_next;

    logic                  now_pressed;
    logic                  rel_hit;
    logic                  press_hit;
    logic                  down_mid;
    logic                  long_mid;
    logic                  long_long_mid;
    logic [HOLD_WIDTH-1:0] hold_inc;

    assign now_pressed   = ~item.button_level;
    assign rel_hit       = (prev_pressed_reg == now_pressed) && !now_pressed && !is_up_reg;
    assign press_hit     = (prev_pressed_reg == now_pressed) && now_pressed && !is_down_reg;
    assign down_mid      = press_hit | (is_down_reg & ~rel_hit);
    assign long_mid      = long_reg & ~rel_hit;
    assign long_long_mid = long_long_reg & ~rel_hit;
    assign hold_inc      = (hold_reg != {HOLD_WIDTH{1'b1}}) ? hold_reg + 1'b1 : hold_reg;

    always_comb begin
        ev                = '0;
        prev_pressed_next = prev_pressed_reg;
        is_up_next        = is_up_reg;
        is_down_next      = is_down_reg;
        long_next         = long_reg;
        long_long_next    = long_long_reg;
        hold_next         = hold_reg;
        if (item.mode == MODE_TICK) begin
            ev.released   = rel_hit;
            ev.pressed    = press_hit;
            ev.long_click = rel_hit & is_down_reg & long_reg;
            ev.click      = rel_hit & is_down_reg & ~long_reg;
            if (down_mid) begin
                ev.long_down      = !long_mid && (hold_inc >= long_press_ticks);
                ev.long_long_down = !long_long_mid && (hold_inc >= long_long_press_ticks);
            end
        end
        if (step_en && item.mode == MODE_TICK) begin
            prev_pressed_next = now_pressed;
            is_up_next        = rel_hit | (is_up_reg & ~press_hit);
            is_down_next      = down_mid;
            long_next         = long_mid | ev.long_down;
            long_long_next    = long_long_mid | ev.long_long_down;
            hold_next         = down_mid ? hold_inc : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pressed_reg <= 1'b0;
            is_up_reg        <= 1'b1;
            is_down_reg      <= 1'b0;
            long_reg         <= 1'b0;
            long_long_reg    <= 1'b0;
            hold_reg         <= '0;
        end else begin
            prev_pressed_reg <= prev_pressed_next;
            is_up_reg        <= is_up_next;
            is_down_reg      <= is_down_next;
            long_reg         <= long_next;
            long_long_reg    <= long_long_next;
            hold_reg         <= hold_next;
        end
    end

endmodule

### src/rotary_knob_and_button_interface.sv
// Channel   Ports                              Direction  Item
// input     s_valid, s_ready, s_data           in         edge or tick (mode, a_level, pin)
// result    m_valid, m_ready, m_data           out        position, motion and button events
// config    cfg_we, cfg_index, cfg_data        in         one 16-bit register per write
//
// One item per cycle sustained unless m_ready stalls the result register.
// The state update and result sit between the input register and the result register.
// Reset (synchronous, aresetn low) empties both registers and loads register defaults.
// A stalled result holds; the input register still fills, then s_ready drops.
module rotary_knob_and_button_interface #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  rkbi_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output rkbi_pkg::out_item_t                  m_data,
    input  logic                                 cfg_we,
    input  logic [rkbi_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rkbi_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import rkbi_pkg::*;

    logic [CFG_DATA_WIDTH-1:0] move_thr_reg;
    logic [CFG_DATA_WIDTH-1:0] long_ticks_reg;
    logic [CFG_DATA_WIDTH-1:0] long_long_ticks_reg;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    logic      advance;

    knob_res_t knob_res;
    btn_ev_t   btn_ev;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_thr_reg        <= RST_MOVE_THRESHOLD;
            long_ticks_reg      <= RST_LONG_PRESS_TICKS;
            long_long_ticks_reg <= RST_LONG_LONG_PRESS_TICKS;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MOVE_THRESHOLD:        move_thr_reg        <= cfg_data;
                CFG_LONG_PRESS_TICKS:      long_ticks_reg      <= cfg_data;
                CFG_LONG_LONG_PRESS_TICKS: long_long_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    rkbi_knob #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_knob (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .item          (in_item_reg),
        .move_threshold(move_thr_reg),
        .res           (knob_res)
    );

    rkbi_button u_button (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .step_en              (advance),
        .item                 (in_item_reg),
        .long_press_ticks     (long_ticks_reg),
        .long_long_press_ticks(long_long_ticks_reg),
        .ev                   (btn_ev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
        if (advance) begin
            out_item_reg.position       <= knob_res.position;
            out_item_reg.moved          <= knob_res.moved;
            out_item_reg.direction      <= knob_res.direction;
            out_item_reg.pressed        <= btn_ev.pressed;
            out_item_reg.released       <= btn_ev.released;
            out_item_reg.click          <= btn_ev.click;
            out_item_reg.long_click     <= btn_ev.long_click;
            out_item_reg.long_down      <= btn_ev.long_down;
            out_item_reg.long_long_down <= btn_ev.long_long_down;
        end
    end

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed item did not reach the result register");

    a_click_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.click && m_data.long_click))
        else $error("click and long click in one item");

    a_click_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.click || m_data.long_click)) |-> m_data.released)
        else $error("click without release");

    a_edge_no_events: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.mode == MODE_EDGE) |=>
            !(m_data.moved || m_data.direction || m_data.pressed || m_data.released))
        else $error("edge item produced tick results");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input register refused an item");

endmodule

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import rkbi_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_UNUSED_INDEX = 2'd3;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e                  kind;
        in_item_t                   item;
        logic                       typed;
        out_item_t                  want;
        logic [CFG_INDEX_WIDTH-1:0] reg_idx;
        logic [CFG_DATA_WIDTH-1:0]  reg_val;
    } dir_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    in_item_t                   s_data = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    out_item_t                  m_data;
    logic                       cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;

    out_item_t results_due[$];
    out_item_t got_want;

    logic [CFG_DATA_WIDTH-1:0] thr_move;
    logic [CFG_DATA_WIDTH-1:0] thr_long;
    logic [CFG_DATA_WIDTH-1:0] thr_long_long;

    logic [31:0]           edges_total;
    logic [31:0]           edges_taken;
    logic [POS_WIDTH-1:0]  pos_acc;
    logic [POS_WIDTH-1:0]  pos_reported;
    logic                  pin_was_down;
    logic                  btn_up;
    logic                  btn_down;
    logic                  long_hit;
    logic                  long_long_hit;
    logic [HOLD_WIDTH-1:0] held_ticks;

    logic pin_level;
    int   pin_left;

    rotary_knob_and_button_interface u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end

    task automatic knob_predict(input in_item_t it, output out_item_t r);
        logic [31:0] delta;
        logic [31:0] gap;
        logic [31:0] mag;
        logic        now_down;
        r = '0;
        if (it.mode == MODE_EDGE) begin
            edges_total = it.a_level ? edges_total + 32'd1 : edges_total - 32'd1;
        end else begin
            delta = edges_total - edges_taken;
            r.direction = delta[31];
            edges_taken = edges_total;
            pos_acc = pos_acc + delta;
            gap = pos_acc - pos_reported;
            mag = gap[31] ? 32'd0 - gap : gap;
            if (mag > {16'd0, thr_move}) begin
                pos_reported = pos_acc;
                r.moved = 1'b1;
            end
            now_down = !it.button_level;
            if (pin_was_down == now_down && !now_down && !btn_up) begin
                if (btn_down) begin
                    if (long_hit) r.long_click = 1'b1;
                    else r.click = 1'b1;
                end
                btn_up = 1'b1;
                btn_down = 1'b0;
                long_hit = 1'b0;
                long_long_hit = 1'b0;
                r.released = 1'b1;
            end
            if (pin_was_down == now_down && now_down && !btn_down) begin
                btn_up = 1'b0;
                btn_down = 1'b1;
                r.pressed = 1'b1;
            end
            pin_was_down = now_down;
            if (btn_down) begin
                if (held_ticks != '1) held_ticks = held_ticks + 1'b1;
                if (!long_hit && held_ticks >= thr_long) begin
                    long_hit = 1'b1;
                    r.long_down = 1'b1;
                end
                if (!long_long_hit && held_ticks >= thr_long_long) begin
                    long_long_hit = 1'b1;
                    r.long_long_down = 1'b1;
                end
            end else begin
                held_ticks = '0;
            end
        end
        r.position = pos_acc;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result item with nothing expected: %0h", m_data);
            end else begin
                got_want = results_due.pop_front();
                check_field("position", got_want.position, m_data.position);
                check_field("moved", 32'(got_want.moved), 32'(m_data.moved));
                check_field("direction", 32'(got_want.direction), 32'(m_data.direction));
                check_field("pressed", 32'(got_want.pressed), 32'(m_data.pressed));
                check_field("released", 32'(got_want.released), 32'(m_data.released));
                check_field("click", 32'(got_want.click), 32'(m_data.click));
                check_field("long_click", 32'(got_want.long_click),
                            32'(m_data.long_click));
                check_field("long_down", 32'(got_want.long_down), 32'(m_data.long_down));
                check_field("long_long_down", 32'(got_want.long_long_down),
                            32'(m_data.long_long_down));
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic push_item(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t p;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        knob_predict(it, p);
        results_due.push_back(typed ? want : p);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        case (idx)
            CFG_MOVE_THRESHOLD:        thr_move = val;
            CFG_LONG_PRESS_TICKS:      thr_long = val;
            CFG_LONG_LONG_PRESS_TICKS: thr_long_long = val;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_WIDTH-1:0] mv,
                            input logic [CFG_DATA_WIDTH-1:0] lp,
                            input logic [CFG_DATA_WIDTH-1:0] llp);
        write_reg(CFG_MOVE_THRESHOLD, mv);
        write_reg(CFG_LONG_PRESS_TICKS, lp);
        write_reg(CFG_LONG_LONG_PRESS_TICKS, llp);
    endtask

    function automatic in_item_t mk_item(input logic md, input logic a, input logic pin);
        in_item_t it;
        it.mode = md;
        it.a_level = a;
        it.button_level = pin;
        return it;
    endfunction

    function automatic out_item_t knob_out(input int pos, input logic mv, input logic dr);
        out_item_t r;
        r = '0;
        r.position = pos;
        r.moved = mv;
        r.direction = dr;
        return r;
    endfunction

    function automatic dir_row_t item_row(input logic md, input logic a, input logic pin);
        dir_row_t r;
        r.kind = ROW_ITEM;
        r.item = mk_item(md, a, pin);
        r.typed = 1'b0;
        r.want = '0;
        r.reg_idx = '0;
        r.reg_val = '0;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input logic md, input logic a, input logic pin,
                                           input out_item_t want);
        dir_row_t r;
        r = item_row(md, a, pin);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                         input logic [CFG_DATA_WIDTH-1:0] val);
        dir_row_t r;
        r = item_row(MODE_EDGE, 1'b0, 1'b0);
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    task automatic random_burst();
        int       n_edges;
        logic     up;
        logic     pin;
        in_item_t it;
        if ($urandom_range(9) == 0) begin
            it = mk_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
            push_item(it, 1'b0, '0);
            return;
        end
        n_edges = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4);
        up = 1'($urandom_range(1));
        repeat (n_edges) begin
            it = mk_item(MODE_EDGE, ($urandom_range(9) < 8) ? up : !up,
                         1'($urandom_range(1)));
            push_item(it, 1'b0, '0);
        end
        if (pin_left == 0) begin
            pin_level = !pin_level;
            pin_left = pin_level ? $urandom_range(1, 6) : $urandom_range(1, 25);
        end
        pin_left--;
        pin = pin_level;
        if ($urandom_range(19) == 0) pin = !pin;
        push_item(mk_item(MODE_TICK, 1'($urandom_range(1)), pin), 1'b0, '0);
    endtask

    task automatic random_phase(input int n);
        repeat (n) random_burst();
    endtask

    dir_row_t rows[$];

    initial begin
        thr_move = RST_MOVE_THRESHOLD;
        thr_long = RST_LONG_PRESS_TICKS;
        thr_long_long = RST_LONG_LONG_PRESS_TICKS;
        edges_total = '0;
        edges_taken = '0;
        pos_acc = '0;
        pos_reported = '0;
        pin_was_down = 1'b0;
        btn_up = 1'b1;
        btn_down = 1'b0;
        long_hit = 1'b0;
        long_long_hit = 1'b0;
        held_ticks = '0;
        pin_level = 1'b1;
        pin_left = 0;

        rows.push_back(typed_row(MODE_TICK, 1'b0, 1'b1, knob_out(0, 1'b0, 1'b0)));
        rows.push_back(typed_row(MODE_EDGE, 1'b1, 1'b0, knob_out(0, 1'b0, 1'b0)));
        rows.push_back(typed_row(MODE_EDGE, 1'b1, 1'b1, knob_out(0, 1'b0, 1'b0)));
        rows.push_back(typed_row(MODE_TICK, 1'b0, 1'b1, knob_out(2, 1'b1, 1'b0)));
        rows.push_back(typed_row(MODE_EDGE, 1'b0, 1'b0, knob_out(2, 1'b0, 1'b0)));
        rows.push_back(typed_row(MODE_TICK, 1'b1, 1'b1, knob_out(1, 1'b0, 1'b1)));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b0));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b0));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b1));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b1));
        rows.push_back(cfg_row(CFG_LONG_PRESS_TICKS, 16'h0000));
        rows.push_back(cfg_row(CFG_LONG_LONG_PRESS_TICKS, 16'h0000));
        rows.push_back(cfg_row(CFG_UNUSED_INDEX, 16'hFFFF));
        rows.push_back(cfg_row(CFG_MOVE_THRESHOLD, 16'hFFFF));
        rows.push_back(item_row(MODE_TICK, 1'b1, 1'b0));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b0));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b1));
        rows.push_back(item_row(MODE_TICK, 1'b1, 1'b1));
        rows.push_back(item_row(MODE_EDGE, 1'b0, 1'b1));
        rows.push_back(item_row(MODE_EDGE, 1'b0, 1'b0));
        rows.push_back(item_row(MODE_EDGE, 1'b0, 1'b1));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b1));
        rows.push_back(cfg_row(CFG_MOVE_THRESHOLD, 16'h0002));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b1));
        rows.push_back(cfg_row(CFG_MOVE_THRESHOLD, 16'h0000));
        rows.push_back(item_row(MODE_EDGE, 1'b1, 1'b1));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b1));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b0));
        rows.push_back(item_row(MODE_TICK, 1'b0, 1'b1));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) write_reg(rows[i].reg_idx, rows[i].reg_val);
            else push_item(rows[i].item, rows[i].typed, rows[i].want);
        end

        idle_pct = 0;
        stall_pct = 0;
        set_regs(16'($urandom_range(0, 3)), 16'($urandom_range(2, 8)),
                 16'($urandom_range(8, 20)));
        random_phase(50);

        idle_pct = 86;
        stall_pct = 0;
        set_regs(16'd0, 16'd0, 16'd0);
        random_phase(50);

        idle_pct = 0;
        stall_pct = 86;
        set_regs(16'($urandom_range(0, 6)), 16'($urandom_range(1, 10)),
                 16'($urandom_range(5, 25)));
        random_phase(50);

        idle_pct = 21;
        stall_pct = 21;
        write_reg(CFG_UNUSED_INDEX, 16'($urandom_range(16'hFFFF)));
        set_regs(16'($urandom_range(0, 16'hFFFF) % 8), 16'($urandom_range(0, 12)),
                 16'($urandom_range(0, 30)));
        random_phase(50);

        stall_pct = 0;
        drain();
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end
endmodule
